// ----- rtl/core/sbb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbb_pkg: shared definitions for the spectrum bar ballistics block
// Q1.15 level types, per-bar state entry, register map and reset values.
// ----------------------------------------------------------------------------
package sbb_pkg;

  // Default geometry
  localparam int DEF_MAX_BARS = 256;
  localparam int DEF_CHANNELS = 2;

  // Field widths
  localparam int LVL_W  = 16;
  localparam int AGE_W  = 16;
  localparam int GAP_W  = 12;
  localparam int HOLD_W = 8;
  localparam int BAR_W  = 8;
  localparam int PROD_W = GAP_W + LVL_W;

  typedef logic [LVL_W-1:0]  q15_t;
  typedef logic [AGE_W-1:0]  age_t;
  typedef logic [GAP_W-1:0]  gap_t;
  typedef logic [HOLD_W-1:0] hold_t;
  typedef logic [PROD_W-1:0] prod_t;

  localparam q15_t FULL_SCALE = 16'd32768;
  localparam age_t AGE_MAX    = 16'hFFFF;

  // Register reset values
  localparam q15_t  RELEASE_STEP_RST = 16'd468;
  localparam q15_t  FALL_STEP_RST    = 16'd351;
  localparam hold_t HOLD_FRAMES_RST  = 8'd30;

  // Register map (word index, byte address = 4 * index)
  localparam int REG_IDX_W = 2;
  localparam int PADDR_W   = REG_IDX_W + 2;
  localparam logic [REG_IDX_W-1:0] REG_RELEASE_STEP = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_FALL_STEP    = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_HOLD_FRAMES  = 2'd2;

  // Per-bar state as held in the state memory
  typedef struct packed {
    q15_t smoothed;
    q15_t peak;
    age_t age;
  } entry_t;

  // Pipeline stage control
  typedef struct packed {
    logic vld;  // stage holds a request
    logic inr;  // channel and bar are inside the store
  } tag_t;

endpackage

// ----- rtl/core/sbb_math.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbb_math: four-stage update pipeline for one bar's ballistics
// Takes the fetched state and applies restart, silent decay, attack/release
// and peak hold/fall. Stage D presents the new state for write-back.
// ----------------------------------------------------------------------------
module sbb_math #(
  parameter int AW = 9
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  // accepted request
  input  logic                acc,
  input  logic [AW-1:0]       acc_addr,
  input  logic                acc_inr,
  input  sbb_pkg::q15_t       acc_level,
  input  sbb_pkg::gap_t       acc_gap,
  input  logic                acc_restart,
  // state read, valid while the request sits in stage A
  input  sbb_pkg::entry_t     rd_data,
  // configuration
  input  sbb_pkg::q15_t       release_step,
  input  sbb_pkg::q15_t       fall_step,
  input  sbb_pkg::hold_t      hold_frames,
  // same-bar check against requests not yet written back
  input  logic [AW-1:0]       probe_addr,
  output logic                probe_hit,
  // write-back / result
  output sbb_pkg::tag_t       wr_tag,
  output logic [AW-1:0]       wr_addr,
  output sbb_pkg::entry_t     wr_data
);

  // Stage A: request fields, state arrives from memory
  sbb_pkg::tag_t   a_tag_r;
  logic [AW-1:0]   a_addr_r;
  sbb_pkg::q15_t   a_lvl_r;
  sbb_pkg::gap_t   a_gap_r;
  logic            a_rst_r;

  // Stage B
  sbb_pkg::tag_t   b_tag_r;
  logic [AW-1:0]   b_addr_r;
  sbb_pkg::q15_t   b_lvl_r;
  sbb_pkg::gap_t   b_gap_r;
  sbb_pkg::q15_t   b_s_r;
  sbb_pkg::q15_t   b_p_r;
  sbb_pkg::age_t   b_age_r;
  sbb_pkg::prod_t  b_prods_r;
  sbb_pkg::gap_t   b_fall_r;

  // Stage C
  sbb_pkg::tag_t   c_tag_r;
  logic [AW-1:0]   c_addr_r;
  sbb_pkg::q15_t   c_lvl_r;
  logic            c_gapnz_r;
  sbb_pkg::q15_t   c_s1_r;
  sbb_pkg::q15_t   c_p_r;
  sbb_pkg::age_t   c_age_r;
  sbb_pkg::prod_t  c_prodp_r;

  // Stage D
  sbb_pkg::tag_t   d_tag_r;
  logic [AW-1:0]   d_addr_r;
  sbb_pkg::q15_t   d_lvl_r;
  sbb_pkg::q15_t   d_s2_r;
  sbb_pkg::q15_t   d_p1_r;
  sbb_pkg::age_t   d_age_inc_r;

  // Stage A logic: restart, decay products, falling frame count
  sbb_pkg::entry_t a_st;
  sbb_pkg::gap_t   a_gap_eff;
  sbb_pkg::prod_t  a_prods;
  logic [sbb_pkg::AGE_W:0] a_sum;
  sbb_pkg::age_t   a_mx;
  sbb_pkg::gap_t   a_fall;

  always_comb begin
    a_st      = a_rst_r ? '0 : rd_data;
    a_gap_eff = a_rst_r ? '0 : a_gap_r;
    a_prods   = sbb_pkg::PROD_W'(a_gap_eff) * sbb_pkg::PROD_W'(release_step);
    a_sum     = (sbb_pkg::AGE_W+1)'(a_st.age) + (sbb_pkg::AGE_W+1)'(a_gap_eff);
    a_mx      = (a_st.age >= sbb_pkg::AGE_W'(hold_frames)) ? a_st.age
                                                           : sbb_pkg::AGE_W'(hold_frames);
    // never more than the gap itself
    if (a_sum > (sbb_pkg::AGE_W+1)'(a_mx)) begin
      a_fall = sbb_pkg::GAP_W'(a_sum - (sbb_pkg::AGE_W+1)'(a_mx));
    end else begin
      a_fall = '0;
    end
  end

  // Stage B logic: smoothed decay, peak decay product, age over the gap
  sbb_pkg::q15_t   b_s1;
  sbb_pkg::prod_t  b_prodp;
  logic [sbb_pkg::AGE_W:0] b_age_sum;
  sbb_pkg::age_t   b_age_g;

  always_comb begin
    if (sbb_pkg::PROD_W'(b_s_r) > b_prods_r) begin
      b_s1 = sbb_pkg::LVL_W'(sbb_pkg::PROD_W'(b_s_r) - b_prods_r);
    end else begin
      b_s1 = '0;
    end
    b_prodp   = sbb_pkg::PROD_W'(b_fall_r) * sbb_pkg::PROD_W'(fall_step);
    b_age_sum = (sbb_pkg::AGE_W+1)'(b_age_r) + (sbb_pkg::AGE_W+1)'(b_gap_r);
    b_age_g   = b_age_sum[sbb_pkg::AGE_W] ? sbb_pkg::AGE_MAX
                                          : b_age_sum[sbb_pkg::AGE_W-1:0];
  end

  // Stage C logic: decayed peak, attack/release, age step
  sbb_pkg::q15_t   c_pdec;
  sbb_pkg::q15_t   c_p1;
  sbb_pkg::q15_t   c_srel;
  sbb_pkg::q15_t   c_s2;
  sbb_pkg::age_t   c_age_inc;

  always_comb begin
    if (sbb_pkg::PROD_W'(c_p_r) > c_prodp_r) begin
      c_pdec = sbb_pkg::LVL_W'(sbb_pkg::PROD_W'(c_p_r) - c_prodp_r);
    end else begin
      c_pdec = '0;
    end
    if (c_gapnz_r) begin
      c_p1 = (c_s1_r > c_pdec) ? c_s1_r : c_pdec;
    end else begin
      c_p1 = c_p_r;
    end
    c_srel    = (c_s1_r > release_step) ? (c_s1_r - release_step) : '0;
    c_s2      = (c_lvl_r > c_srel) ? c_lvl_r : c_srel;
    c_age_inc = (c_age_r == sbb_pkg::AGE_MAX) ? c_age_r
                                              : (c_age_r + sbb_pkg::AGE_W'(1));
  end

  // Stage D logic: peak capture, hold, fall floored at smoothed level
  sbb_pkg::q15_t   d_pfall;
  sbb_pkg::q15_t   d_p;
  sbb_pkg::age_t   d_age;

  always_comb begin
    d_pfall = (d_p1_r > fall_step) ? (d_p1_r - fall_step) : '0;
    if (d_lvl_r >= d_p1_r) begin
      d_p   = d_lvl_r;
      d_age = '0;
    end else begin
      d_age = d_age_inc_r;
      if (d_age_inc_r > sbb_pkg::AGE_W'(hold_frames)) begin
        d_p = (d_s2_r > d_pfall) ? d_s2_r : d_pfall;
      end else begin
        d_p = d_p1_r;
      end
    end
  end

  assign wr_tag  = d_tag_r;
  assign wr_addr = d_addr_r;
  assign wr_data = '{smoothed: d_s2_r, peak: d_p, age: d_age};

  // Requests in A..C have not reached the memory yet
  assign probe_hit = (a_tag_r.vld && a_tag_r.inr && (a_addr_r == probe_addr)) ||
                     (b_tag_r.vld && b_tag_r.inr && (b_addr_r == probe_addr)) ||
                     (c_tag_r.vld && c_tag_r.inr && (c_addr_r == probe_addr));

  // Stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_tag_r <= '0;
      b_tag_r <= '0;
      c_tag_r <= '0;
      d_tag_r <= '0;
    end else if (en) begin
      a_tag_r <= acc ? sbb_pkg::tag_t'{vld: 1'b1, inr: acc_inr} : sbb_pkg::tag_t'('0);
      b_tag_r <= a_tag_r;
      c_tag_r <= b_tag_r;
      d_tag_r <= c_tag_r;
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (en) begin
      a_addr_r    <= acc_addr;
      a_lvl_r     <= acc_level;
      a_gap_r     <= acc_gap;
      a_rst_r     <= acc_restart;

      b_addr_r    <= a_addr_r;
      b_lvl_r     <= a_lvl_r;
      b_gap_r     <= a_gap_eff;
      b_s_r       <= a_st.smoothed;
      b_p_r       <= a_st.peak;
      b_age_r     <= a_st.age;
      b_prods_r   <= a_prods;
      b_fall_r    <= a_fall;

      c_addr_r    <= b_addr_r;
      c_lvl_r     <= b_lvl_r;
      c_gapnz_r   <= (b_gap_r != '0);
      c_s1_r      <= b_s1;
      c_p_r       <= b_p_r;
      c_age_r     <= b_age_g;
      c_prodp_r   <= b_prodp;

      d_addr_r    <= c_addr_r;
      d_lvl_r     <= c_lvl_r;
      d_s2_r      <= c_s2;
      d_p1_r      <= c_p1;
      d_age_inc_r <= c_age_inc;
    end
  end

endmodule

// ----- rtl/core/spectrum_bar_ballistics.sv -----
`timescale 1ns / 1ps
// Result path: an accepted request passes stages A to D and the output register to out_*.
// Throughput: one request per cycle while out_* does not stall; a request for a bar that a
//   request in stages A to C also updates waits until that update reaches the state memory.
// Reset: after rst_n the state memory is cleared one entry per cycle, all CHANNELS*MAX_BARS
//   entries (512 by default), with in_ready low; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
// spectrum_bar_ballistics: peak-hold level meter ballistics per spectrum bar
// Per-bar smoothed level, peak and peak age live in one state memory that is
// read at accept, updated in a four-stage pipeline and written back.
// ----------------------------------------------------------------------------
module spectrum_bar_ballistics #(
  parameter int MAX_BARS = sbb_pkg::DEF_MAX_BARS,
  parameter int CHANNELS = sbb_pkg::DEF_CHANNELS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_channel,
  input  logic [sbb_pkg::BAR_W-1:0]   in_bar,
  input  logic [sbb_pkg::LVL_W-1:0]   in_level,
  input  logic [sbb_pkg::GAP_W-1:0]   in_silent_frames,
  input  logic                        in_restart,
  // result channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [sbb_pkg::LVL_W-1:0]   out_smoothed_level,
  output logic [sbb_pkg::LVL_W-1:0]   out_peak_level,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sbb_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int DEPTH = CHANNELS * MAX_BARS;
  localparam int AW    = $clog2(DEPTH);

  // Configuration registers
  sbb_pkg::q15_t  release_step_r;
  sbb_pkg::q15_t  fall_step_r;
  sbb_pkg::hold_t hold_frames_r;
  logic [sbb_pkg::REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[sbb_pkg::PADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      release_step_r <= sbb_pkg::RELEASE_STEP_RST;
      fall_step_r    <= sbb_pkg::FALL_STEP_RST;
      hold_frames_r  <= sbb_pkg::HOLD_FRAMES_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        sbb_pkg::REG_RELEASE_STEP: release_step_r <= pwdata[sbb_pkg::LVL_W-1:0];
        sbb_pkg::REG_FALL_STEP:    fall_step_r    <= pwdata[sbb_pkg::LVL_W-1:0];
        sbb_pkg::REG_HOLD_FRAMES:  hold_frames_r  <= pwdata[sbb_pkg::HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (reg_idx)
      sbb_pkg::REG_RELEASE_STEP: prdata = 32'(release_step_r);
      sbb_pkg::REG_FALL_STEP:    prdata = 32'(fall_step_r);
      sbb_pkg::REG_HOLD_FRAMES:  prdata = 32'(hold_frames_r);
      default:                   prdata = '0;
    endcase
  end

  // Request decode: store index, range check, level saturation
  logic [31:0]      in_idx;
  logic [AW-1:0]    in_addr;
  logic             in_inr;
  sbb_pkg::q15_t    in_lvl_sat;

  assign in_idx     = (in_channel ? 32'(MAX_BARS) : 32'd0) + 32'(in_bar);
  assign in_addr    = in_idx[AW-1:0];
  assign in_inr     = (32'(in_channel) < 32'(CHANNELS)) && (32'(in_bar) < 32'(MAX_BARS));
  assign in_lvl_sat = (in_level > sbb_pkg::FULL_SCALE) ? sbb_pkg::FULL_SCALE : in_level;

  // Flow control
  logic             stall;
  logic             adv;
  logic             acc;
  logic             probe_hit;
  logic             clr_busy_r;

  assign stall    = out_valid && !out_ready;
  assign adv      = !stall;
  assign in_ready = !clr_busy_r && adv && !(in_inr && probe_hit);
  assign acc      = in_valid && in_ready;

  // Update pipeline
  sbb_pkg::tag_t    wr_tag;
  logic [AW-1:0]    wr_addr;
  sbb_pkg::entry_t  wr_data;
  sbb_pkg::entry_t  rd_data_r;

  sbb_math #(
    .AW (AW)
  ) u_math (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (adv),
    .acc          (acc),
    .acc_addr     (in_addr),
    .acc_inr      (in_inr),
    .acc_level    (in_lvl_sat),
    .acc_gap      (in_silent_frames),
    .acc_restart  (in_restart),
    .rd_data      (rd_data_r),
    .release_step (release_step_r),
    .fall_step    (fall_step_r),
    .hold_frames  (hold_frames_r),
    .probe_addr   (in_addr),
    .probe_hit    (probe_hit),
    .wr_tag       (wr_tag),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data)
  );

  // Clearing pass after reset
  logic [AW-1:0]    clr_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clr_busy_r) begin
      clr_idx_r <= clr_idx_r + 1'b1;
      if (clr_idx_r == AW'(DEPTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // State memory write port
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  sbb_pkg::entry_t  mem_wdata;

  always_comb begin
    if (clr_busy_r) begin
      mem_we    = 1'b1;
      mem_waddr = clr_idx_r;
      mem_wdata = '0;
    end else begin
      mem_we    = adv && wr_tag.vld && wr_tag.inr;
      mem_waddr = wr_addr;
      mem_wdata = wr_data;
    end
  end

  // State memory, read at accept with bypass of a same-edge write-back
  sbb_pkg::entry_t  mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      if (mem_we && (mem_waddr == in_addr)) begin
        rd_data_r <= mem_wdata;
      end else begin
        rd_data_r <= mem_r[in_addr];
      end
    end
  end

  // Output register
  logic             out_valid_r;
  sbb_pkg::q15_t    out_smoothed_r;
  sbb_pkg::q15_t    out_peak_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= wr_tag.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && wr_tag.vld) begin
      out_smoothed_r <= wr_tag.inr ? wr_data.smoothed : '0;
      out_peak_r     <= wr_tag.inr ? wr_data.peak : '0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_smoothed_level = out_smoothed_r;
  assign out_peak_level     = out_peak_r;

endmodule
